// ===== rtl/ppd_pkg.sv =====
// Package for the profile peak detector: transaction structs, register
// indexes, configuration struct, scan state and fixed widths.
// No dependencies.
`default_nettype none

package ppd_pkg;

  // fixed widths of the fields and of the internal level scale
  localparam int SAMPLE_W = 15;
  localparam int X_W      = 12;
  localparam int STEP_W   = 8;
  localparam int DIST_W   = 16;
  localparam int COUNT_W  = 5;
  localparam int LEVEL_W  = 19;  // 15 * sample or 5 * (three samples)
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // bias on the first point: 0.1 percent in units of 1/3840 percent
  localparam logic [LEVEL_W-1:0] BIAS_FIRST = LEVEL_W'(384);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // result queue depth
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;

  // result kinds
  localparam logic KIND_PEAK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_X          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THRESHOLD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DISTANCE = 3'd6;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last_sample;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [X_W-1:0]     peak_x;
    logic [COUNT_W-1:0] car_count;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic [X_W-1:0]      start_x;
    logic [X_W-1:0]      end_x;
    logic [STEP_W-1:0]   x_step;
    logic [SAMPLE_W-1:0] detect_threshold;
    logic [X_W-1:0]      min_distance;
    logic [SAMPLE_W-1:0] rise_threshold;
    logic [DIST_W-1:0]   initial_distance;
  } cfg_t;

  // tracking state carried from point to point
  typedef struct packed {
    logic [X_W-1:0]     x_position;
    logic [LEVEL_W-1:0] previous_level;
    logic               rising;
    logic [DIST_W-1:0]  distance;
  } scan_st_t;

  // results pushed into the queue together, up to two
  typedef struct packed {
    logic [1:0] n;
    out_t       d0;
    out_t       d1;
  } push_t;

  // stage phases
  typedef enum logic [1:0] {
    PH_MAIN = 2'b01,
    PH_LAST = 2'b10
  } ph_t;

  // times fifteen, widened to the level scale
  function automatic logic [LEVEL_W-1:0] times15(input logic [SAMPLE_W-1:0] v);
    logic [LEVEL_W-1:0] w;
    w = LEVEL_W'(v);
    return (w << 4) - w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppd_scan.sv =====
// Judges one point of the smoothed profile: rise/fall tracking, peak test,
// distance test and position advance. Combinational. Depends on ppd_pkg.
`default_nettype none

module ppd_scan import ppd_pkg::*; #(
  parameter int MAX_CARS = 20,
  localparam int CW = $clog2(MAX_CARS)
) (
  input  cfg_t               cfg,
  input  logic               en,
  input  logic [LEVEL_W-1:0] level,
  input  logic               first,
  input  scan_st_t           st_i,
  input  logic [CW-1:0]      cnt_i,
  output scan_st_t           st_o,
  output logic [CW-1:0]      cnt_o,
  output logic               peak,
  output logic [X_W-1:0]     peak_x
);

  localparam logic [CW:0] CNT_LIMIT = (CW+1)'(MAX_CARS);
  localparam logic [CW:0] CNT_TOP   = (CW+1)'(MAX_CARS - 1);

  logic               active;
  logic               rising0;
  logic [LEVEL_W-1:0] prev0;
  logic               falling;
  logic               far;
  logic signed [12:0] span;
  logic [X_W-1:0]     span_u;
  logic [14:0]        span5;
  logic signed [12:0] travelled;
  logic signed [17:0] scaled_term;
  logic [30:0]        lhs;
  logic signed [31:0] rhs;
  logic [CW:0]        cnt_inc;
  logic [DIST_W:0]    dist_sum;

  // scan window
  assign active = en && (st_i.x_position > cfg.end_x);

  // seed the first point
  assign rising0 = first ? (level > times15(cfg.rise_threshold)) : st_i.rising;
  assign prev0   = first ? (level + BIAS_FIRST) : st_i.previous_level;
  assign falling = (level < prev0) && rising0;

  // distance test: 5*dist*D > md*(5*D - 4*(start_x - x))
  assign span        = $signed({1'b0, cfg.start_x}) - $signed({1'b0, cfg.end_x});
  assign span_u      = span[X_W-1:0];
  assign span5       = 15'({span_u, 2'b00}) + 15'(span_u);
  assign travelled   = $signed({1'b0, cfg.start_x}) - $signed({1'b0, st_i.x_position});
  assign scaled_term = $signed({3'b000, span5})
                     - $signed({{3{travelled[12]}}, travelled, 2'b00});
  assign lhs = {15'd0, st_i.distance} * {16'd0, span5};
  assign rhs = $signed({20'd0, cfg.min_distance})
             * $signed({{14{scaled_term[17]}}, scaled_term});

  always_comb begin
    if (span <= 13'sd0) begin
      far = st_i.distance > DIST_W'(cfg.min_distance);
    end else begin
      far = $signed({1'b0, lhs}) > rhs;
    end
  end

  // count with the drop back below the limit
  assign cnt_inc  = {1'b0, cnt_i} + (CW+1)'(1);
  assign dist_sum = {1'b0, st_i.distance} + (DIST_W+1)'(cfg.x_step);

  always_comb begin
    st_o   = st_i;
    cnt_o  = cnt_i;
    peak   = 1'b0;
    peak_x = st_i.x_position;
    if (active) begin
      peak = falling && (prev0 > times15(cfg.detect_threshold)) && far;
      if (peak) begin
        cnt_o = (cnt_inc >= CNT_LIMIT) ? CNT_TOP[CW-1:0] : cnt_inc[CW-1:0];
      end
      if (level >= prev0) begin
        st_o.rising = 1'b1;
      end else if (falling) begin
        st_o.rising = 1'b0;
      end else begin
        st_o.rising = rising0;
      end
      st_o.previous_level = level;
      st_o.x_position = (st_i.x_position > X_W'(cfg.x_step))
                      ? st_i.x_position - X_W'(cfg.x_step) : '0;
      if (peak) begin
        st_o.distance = DIST_W'(cfg.x_step);
      end else if (dist_sum[DIST_W]) begin
        st_o.distance = DIST_MAX;
      end else begin
        st_o.distance = dist_sum[DIST_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppd_res_fifo.sv =====
// Result queue: takes up to two result transactions a cycle, hands out one.
// Depends on ppd_pkg.
`default_nettype none

module ppd_res_fifo import ppd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  out_t                 mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_r, wr_nxt;
  logic [RES_PTR_W-1:0] rd_r, rd_nxt;
  logic [RES_PTR_W:0]   cnt_r, cnt_nxt;
  logic                 pop;
  logic [RES_PTR_W-1:0] wr_plus1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  // room for two more entries
  assign room      = (cnt_r <= (RES_PTR_W+1)'(RES_DEPTH - 2));
  assign wr_plus1  = wr_r + RES_PTR_W'(1);

  // advance pointers and fill level
  assign wr_nxt  = wr_r + RES_PTR_W'(push.n);
  assign rd_nxt  = rd_r + RES_PTR_W'(pop);
  assign cnt_nxt = cnt_r + (RES_PTR_W+1)'(push.n) - (RES_PTR_W+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.d0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_plus1] <= push.d1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/profile_peak_detector.sv =====
// Top level of the profile peak detector: configuration registers, input
// stage, smoothing window and tracking state. Uses ppd_pkg, ppd_scan and
// ppd_res_fifo.
//
//   channel | direction | ports                        | payload
//   --------+-----------+------------------------------+--------
//   input   | in        | in_valid, in_stall, in_data  | in_t
//   result  | out       | out_valid, out_stall, out_data | out_t
//   config  | in        | cfg_we, cfg_index, cfg_wdata | 16 bits
//
// An accepted sample sits in the input stage and is judged there by one
// scan unit; a new sample is taken every cycle while the stage is not held.
// A sample marked last holds the stage for a further phase (PH_LAST), in
// which the final point is judged and the summary is queued.
// The stage waits while the four-entry result queue has fewer than two free
// slots. Reset (synchronous, rst_n low) loads the register defaults and
// starts a fresh profile; a summary also starts a fresh profile.
`default_nettype none

module profile_peak_detector import ppd_pkg::*; #(
  parameter int MAX_CARS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_CARS);

  cfg_t cfg_r;

  // input stage
  logic                stg_valid_r, stg_valid_nxt;
  logic [SAMPLE_W-1:0] stg_sample_r;
  logic                stg_last_r;
  ph_t                 phase_r, phase_nxt;

  // smoothing window and tracking state
  logic [SAMPLE_W-1:0] older_r, older_nxt;
  logic [SAMPLE_W-1:0] newer_r, newer_nxt;
  logic [1:0]          seen_r, seen_nxt;
  scan_st_t            st_r, st_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;

  logic               room;
  logic               fire;
  logic               phase_last;
  logic               stage_done;
  logic               accept;
  logic               scan_en;
  logic [LEVEL_W-1:0] scan_level;
  logic               scan_first;
  scan_st_t           scan_st;
  logic [CW-1:0]      scan_cnt;
  logic               scan_peak;
  logic [X_W-1:0]     scan_x;
  logic [16:0]        win_sum;
  logic [CW+4:0]      cnt_wide;
  out_t               peak_res;
  out_t               sum_res;
  push_t              push;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_x          <= X_W'(1023);
      cfg_r.end_x            <= '0;
      cfg_r.x_step           <= STEP_W'(8);
      cfg_r.detect_threshold <= SAMPLE_W'(7680);
      cfg_r.min_distance     <= X_W'(40);
      cfg_r.rise_threshold   <= SAMPLE_W'(2560);
      cfg_r.initial_distance <= DIST_W'(100);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_X:          cfg_r.start_x          <= cfg_wdata[X_W-1:0];
        CFG_END_X:            cfg_r.end_x            <= cfg_wdata[X_W-1:0];
        CFG_X_STEP:           cfg_r.x_step           <= cfg_wdata[STEP_W-1:0];
        CFG_DETECT_THRESHOLD: cfg_r.detect_threshold <= cfg_wdata[SAMPLE_W-1:0];
        CFG_MIN_DISTANCE:     cfg_r.min_distance     <= cfg_wdata[X_W-1:0];
        CFG_RISE_THRESHOLD:   cfg_r.rise_threshold   <= cfg_wdata[SAMPLE_W-1:0];
        CFG_INITIAL_DISTANCE: cfg_r.initial_distance <= cfg_wdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  assign fire       = stg_valid_r && room;
  assign phase_last = (phase_r == PH_LAST);
  assign stage_done = fire && (!stg_last_r || phase_last);
  assign in_stall   = stg_valid_r && !stage_done;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (accept) begin
      stg_valid_nxt = 1'b1;
    end else if (stage_done) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (phase_r)
        PH_MAIN: phase_nxt = stg_last_r ? PH_LAST : PH_MAIN;
        PH_LAST: phase_nxt = PH_MAIN;
        default: phase_nxt = PH_MAIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      phase_r     <= PH_MAIN;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_sample_r <= in_data.sample;
      stg_last_r   <= in_data.last_sample;
    end
  end

  // pick the point to judge: the window's middle point first (the first point raw), the raw last point after
  assign win_sum = 17'(older_r) + 17'(newer_r) + 17'(stg_sample_r);

  always_comb begin
    if (phase_last) begin
      scan_en    = fire;
      scan_level = times15(stg_sample_r);
    end else begin
      scan_en    = fire && (seen_r != 2'd0);
      scan_level = (seen_r == 2'd1) ? times15(newer_r)
                 : (LEVEL_W'({win_sum, 2'b00}) + LEVEL_W'(win_sum));
    end
    scan_first = (seen_r == 2'd1);
  end

  ppd_scan #(
    .MAX_CARS(MAX_CARS)
  ) u_scan (
    .cfg    (cfg_r),
    .en     (scan_en),
    .level  (scan_level),
    .first  (scan_first),
    .st_i   (st_r),
    .cnt_i  (cnt_r),
    .st_o   (scan_st),
    .cnt_o  (scan_cnt),
    .peak   (scan_peak),
    .peak_x (scan_x)
  );

  // build result transactions
  assign cnt_wide = {5'd0, scan_cnt};

  always_comb begin
    peak_res.kind        = KIND_PEAK;
    peak_res.peak_x      = scan_x;
    peak_res.car_count   = cnt_wide[COUNT_W-1:0];
    peak_res.last_result = 1'b0;
    sum_res.kind         = KIND_SUMMARY;
    sum_res.peak_x       = '0;
    sum_res.car_count    = cnt_wide[COUNT_W-1:0];
    sum_res.last_result  = 1'b1;
  end

  always_comb begin
    push.n  = 2'd0;
    push.d0 = peak_res;
    push.d1 = sum_res;
    if (fire && phase_last) begin
      if (scan_peak) begin
        push.n = 2'd2;
      end else begin
        push.n  = 2'd1;
        push.d0 = sum_res;
      end
    end else if (fire && scan_peak) begin
      push.n = 2'd1;
    end
  end

  // update window and tracking state; restart after a summary
  always_comb begin
    older_nxt = older_r;
    newer_nxt = newer_r;
    seen_nxt  = seen_r;
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    if (fire) begin
      st_nxt  = scan_st;
      cnt_nxt = scan_cnt;
      if (phase_last) begin
        older_nxt               = '0;
        newer_nxt               = '0;
        seen_nxt                = 2'd0;
        st_nxt.x_position       = cfg_r.start_x;
        st_nxt.previous_level   = '0;
        st_nxt.rising           = 1'b0;
        st_nxt.distance         = cfg_r.initial_distance;
        cnt_nxt                 = '0;
      end else if (seen_r == 2'd0) begin
        newer_nxt = stg_sample_r;
        seen_nxt  = 2'd1;
      end else begin
        older_nxt = newer_r;
        newer_nxt = stg_sample_r;
        seen_nxt  = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r             <= '0;
      newer_r             <= '0;
      seen_r              <= 2'd0;
      st_r.x_position     <= X_W'(1023);
      st_r.previous_level <= '0;
      st_r.rising         <= 1'b0;
      st_r.distance       <= DIST_W'(100);
      cnt_r               <= '0;
    end else begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      seen_r  <= seen_nxt;
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  ppd_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
